/* rtl/cap_pkg.sv */
// Shared types and constants for the command APDU parser.
// Holds the parse phase and status codes and the result record.
// No dependencies; the files that use it refer to it by scoped names.
package cap_pkg;

    localparam logic [3:0] SM_NIBBLE_RESET = 4'd12;
    localparam logic [2:0] HEADER_LEN      = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT    = 3'd2,
        PH_DATA   = 3'd3,
        PH_LE     = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_EXCESS  = 3'd3,
        ST_ZERO_LC = 3'd4
    } t_status;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic        done_res;
        logic [7:0]  cla;
        logic [7:0]  ins;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [15:0] lc;
        logic [16:0] le;
        logic        extended;
        logic        secure;
        t_status     status;
    } t_result;

endpackage

/* rtl/command_apdu_parser_core.sv */
// Top level of the command APDU parser.
// Connects the input register, the frame parser and the result register.
// Depends on cap_pkg, cap_in_reg, cap_frame and cap_out_reg.
//
// The parser takes one command APDU byte per cycle, with a flag on the final
// byte, and sustains one byte per clock when the result side keeps up. A byte
// passes through the input register and the single-pass frame parser into the
// result register, which holds the result until the downstream side takes it.
// Each command data byte yields a result transaction carrying the byte, and the
// final byte yields one carrying CLA, INS, P1, P2, Lc, Le, the extended and
// secure-messaging flags and a status; bytes of the header and length fields
// yield none. The secure-messaging class nibble resets to 12 and is written
// through i_cfg_we and i_cfg_data; the user must write it only while no frame
// is in flight, as the block itself does not enforce this.
module command_apdu_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_data,
    output logic [7:0]  o_data_byte,
    output logic        o_done_res,
    output logic [7:0]  o_cla,
    output logic [7:0]  o_ins,
    output logic [7:0]  o_p1,
    output logic [7:0]  o_p2,
    output logic [15:0] o_lc,
    output logic [16:0] o_le,
    output logic        o_extended,
    output logic        o_secure,
    output logic [2:0]  o_status
);

    logic             w_stage_valid;
    logic [7:0]       w_stage_byte;
    logic             w_stage_last;
    logic             w_adv;
    logic             w_load;
    cap_pkg::t_result w_res;
    cap_pkg::t_result w_out;

    assign w_adv  = w_stage_valid && (!o_out_valid || i_out_ready);
    assign w_load = w_adv && (w_res.has_data || w_res.done_res);

    cap_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_is_last  (i_is_last),
        .i_take     (w_adv),
        .o_valid    (w_stage_valid),
        .o_byte     (w_stage_byte),
        .o_last     (w_stage_last)
    );

    cap_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (w_adv),
        .i_byte     (w_stage_byte),
        .i_last     (w_stage_last),
        .o_res      (w_res)
    );

    cap_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_res       (w_res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_res       (w_out)
    );

    assign o_has_data  = w_out.has_data;
    assign o_data_byte = w_out.data_byte;
    assign o_done_res  = w_out.done_res;
    assign o_cla       = w_out.cla;
    assign o_ins       = w_out.ins;
    assign o_p1        = w_out.p1;
    assign o_p2        = w_out.p2;
    assign o_lc        = w_out.lc;
    assign o_le        = w_out.le;
    assign o_extended  = w_out.extended;
    assign o_secure    = w_out.secure;
    assign o_status    = w_out.status;

endmodule

/* rtl/cap_in_reg.sv */
// Input register of the command APDU parser.
// Holds one accepted byte and its last flag until the parse stage takes it.
// Depends on nothing but the port list.
module cap_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_is_last,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_in_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_rx_byte;
            r_last <= i_is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

/* rtl/cap_frame.sv */
// Frame parser of the command APDU parser: phase, header and length state.
// Computes the result of one byte in a single pass and holds the SM class register.
// Depends on cap_pkg.
module cap_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_adv,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output cap_pkg::t_result  o_res
);

    cap_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_idx, n_idx;
    logic [3:0][7:0]  r_hdr, n_hdr;
    logic [7:0]       r_lhi, n_lhi;
    logic [15:0]      r_lc, n_lc;
    logic [15:0]      r_left, n_left;
    logic [1:0]       r_lecnt, n_lecnt;
    logic             r_ext, n_ext;
    cap_pkg::t_status r_err, n_err;
    logic [3:0]       r_sm;

    logic [2:0]       w_idx_inc;
    logic [15:0]      w_v;
    logic [15:0]      w_left_dec;
    logic [16:0]      w_le_short;
    logic [16:0]      w_le_ext;
    logic             w_data;
    logic             w_done;
    logic [16:0]      w_le;
    cap_pkg::t_status w_status;

    assign w_idx_inc  = r_idx + 3'd1;
    assign w_v        = {r_lhi, i_byte};
    assign w_left_dec = r_left - 16'd1;
    assign w_le_short = {8'd0, (i_byte == 8'd0), i_byte};
    assign w_le_ext   = {(w_v == 16'd0), w_v};

    // Next frame state for the byte in the input register.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_hdr   = r_hdr;
        n_lhi   = r_lhi;
        n_lc    = r_lc;
        n_left  = r_left;
        n_lecnt = r_lecnt;
        n_ext   = r_ext;
        n_err   = r_err;
        unique case (r_phase)
            cap_pkg::PH_HEADER: begin
                n_hdr[r_idx[1:0]] = i_byte;
                n_idx = w_idx_inc;
                if (!i_last && w_idx_inc >= cap_pkg::HEADER_LEN) begin
                    n_phase = cap_pkg::PH_LEN;
                    n_idx   = 3'd0;
                end
            end
            cap_pkg::PH_LEN: begin
                if (!i_last) begin
                    if (i_byte == 8'd0) begin
                        n_ext   = 1'b1;
                        n_phase = cap_pkg::PH_EXT;
                        n_idx   = 3'd0;
                    end else begin
                        n_lc    = {8'd0, i_byte};
                        n_left  = {8'd0, i_byte};
                        n_phase = cap_pkg::PH_DATA;
                    end
                end
            end
            cap_pkg::PH_EXT: begin
                if (r_idx == 3'd0) begin
                    n_lhi = i_byte;
                    n_idx = 3'd1;
                end else if (!i_last) begin
                    if (w_v == 16'd0) begin
                        n_err   = cap_pkg::ST_ZERO_LC;
                        n_phase = cap_pkg::PH_SKIP;
                    end else begin
                        n_lc    = w_v;
                        n_left  = w_v;
                        n_phase = cap_pkg::PH_DATA;
                    end
                end
            end
            cap_pkg::PH_DATA: begin
                n_left = w_left_dec;
                if (w_left_dec == 16'd0 && !i_last) begin
                    n_phase = cap_pkg::PH_LE;
                    n_lecnt = 2'd0;
                end
            end
            cap_pkg::PH_LE: begin
                if (!r_ext) begin
                    if (!i_last) begin
                        n_err   = cap_pkg::ST_EXCESS;
                        n_phase = cap_pkg::PH_SKIP;
                    end
                end else if (r_lecnt == 2'd0) begin
                    n_lhi   = i_byte;
                    n_lecnt = 2'd1;
                end else if (!i_last) begin
                    n_err   = cap_pkg::ST_EXCESS;
                    n_phase = cap_pkg::PH_SKIP;
                end
            end
            cap_pkg::PH_SKIP: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result of the byte: a data byte, a frame summary, both, or neither.
    always_comb begin
        w_data   = 1'b0;
        w_done   = 1'b0;
        w_le     = 17'd0;
        w_status = cap_pkg::ST_OK;
        unique case (r_phase)
            cap_pkg::PH_HEADER: begin
                if (i_last) begin
                    w_done   = 1'b1;
                    w_status = (w_idx_inc < cap_pkg::HEADER_LEN) ?
                               cap_pkg::ST_SHORT : cap_pkg::ST_OK;
                end
            end
            cap_pkg::PH_LEN: begin
                if (i_last) begin
                    w_done = 1'b1;
                    w_le   = w_le_short;
                end
            end
            cap_pkg::PH_EXT: begin
                if (r_idx == 3'd0) begin
                    if (i_last) begin
                        w_done   = 1'b1;
                        w_status = cap_pkg::ST_TRUNC;
                    end
                end else if (i_last) begin
                    w_done = 1'b1;
                    w_le   = w_le_ext;
                end
            end
            cap_pkg::PH_DATA: begin
                w_data = 1'b1;
                if (i_last) begin
                    w_done = 1'b1;
                    if (w_left_dec != 16'd0) begin
                        w_status = cap_pkg::ST_TRUNC;
                    end
                end
            end
            cap_pkg::PH_LE: begin
                if (i_last) begin
                    w_done = 1'b1;
                    if (!r_ext) begin
                        w_le = w_le_short;
                    end else if (r_lecnt == 2'd0) begin
                        w_status = cap_pkg::ST_TRUNC;
                    end else begin
                        w_le = w_le_ext;
                    end
                end
            end
            cap_pkg::PH_SKIP: begin
                if (i_last) begin
                    w_done   = 1'b1;
                    w_status = r_err;
                end
            end
            default: begin
                if (i_last) begin
                    w_done   = 1'b1;
                    w_status = r_err;
                end
            end
        endcase

        o_res           = '0;
        o_res.has_data  = w_data;
        o_res.data_byte = w_data ? i_byte : 8'd0;
        if (w_done) begin
            o_res.done_res = 1'b1;
            o_res.cla      = n_hdr[0];
            o_res.ins      = n_hdr[1];
            o_res.p1       = n_hdr[2];
            o_res.p2       = n_hdr[3];
            o_res.lc       = (w_status == cap_pkg::ST_SHORT) ? 16'd0 : n_lc;
            o_res.le       = (w_status == cap_pkg::ST_OK) ? w_le : 17'd0;
            o_res.extended = n_ext;
            o_res.secure   = (n_hdr[0][3:0] == r_sm);
            o_res.status   = w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm <= cap_pkg::SM_NIBBLE_RESET;
        end else if (i_cfg_we) begin
            r_sm <= i_cfg_data;
        end
    end

    // The frame state is cleared after the final byte of each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && w_done)) begin
            r_phase <= cap_pkg::PH_HEADER;
            r_idx   <= 3'd0;
            r_hdr   <= '0;
            r_lhi   <= 8'd0;
            r_lc    <= 16'd0;
            r_left  <= 16'd0;
            r_lecnt <= 2'd0;
            r_ext   <= 1'b0;
            r_err   <= cap_pkg::ST_OK;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_hdr   <= n_hdr;
            r_lhi   <= n_lhi;
            r_lc    <= n_lc;
            r_left  <= n_left;
            r_lecnt <= n_lecnt;
            r_ext   <= n_ext;
            r_err   <= n_err;
        end
    end

    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && w_done |=> r_phase == cap_pkg::PH_HEADER && r_idx == 3'd0)
        else $error("Frame state was not cleared after the final byte.");

    a_data_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cap_pkg::PH_DATA |-> r_left != 16'd0)
        else $error("Data phase entered with no data bytes left.");

    a_skip_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cap_pkg::PH_SKIP |->
            (r_err == cap_pkg::ST_EXCESS || r_err == cap_pkg::ST_ZERO_LC))
        else $error("Skip phase without a recorded error.");

    a_ext_phase_needs_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cap_pkg::PH_EXT |-> r_ext)
        else $error("Extended length phase without extended mode.");

endmodule

/* rtl/cap_out_reg.sv */
// Result register of the command APDU parser.
// Holds one result transaction until the downstream side takes it.
// Depends on cap_pkg.
module cap_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cap_pkg::t_result i_res,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output cap_pkg::t_result o_res
);

    logic             r_valid;
    cap_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
